FILE: hw/rtl/dtdn_pkg.sv
// types, constants and tables for the date to day number block
package dtdn_pkg;

  localparam int YearW = 14;
  localparam int MonthW = 4;
  localparam int DayW = 6;
  localparam int NumW = 22;
  localparam int WdayW = 3;
  localparam int MlenW = 5;

  localparam logic [YearW-1:0] YearMax = YearW'(9999);
  // floor(y / 100) == (y * Recip100) >> Recip100Sh for every 14-bit y
  localparam int Recip100W = 13;
  localparam logic [Recip100W-1:0] Recip100 = Recip100W'(5243);
  localparam int Recip100Sh = 19;
  localparam int ProdW = YearW + Recip100W;

  localparam logic [MonthW-1:0] MonJan = MonthW'(1);
  localparam logic [MonthW-1:0] MonFeb = MonthW'(2);
  localparam logic [MonthW-1:0] MonMar = MonthW'(3);
  localparam logic [MonthW-1:0] MonApr = MonthW'(4);
  localparam logic [MonthW-1:0] MonMay = MonthW'(5);
  localparam logic [MonthW-1:0] MonJun = MonthW'(6);
  localparam logic [MonthW-1:0] MonJul = MonthW'(7);
  localparam logic [MonthW-1:0] MonAug = MonthW'(8);
  localparam logic [MonthW-1:0] MonSep = MonthW'(9);
  localparam logic [MonthW-1:0] MonOct = MonthW'(10);
  localparam logic [MonthW-1:0] MonNov = MonthW'(11);
  localparam logic [MonthW-1:0] MonDec = MonthW'(12);

  typedef struct packed {
    logic [YearW-1:0]  year;
    logic [MonthW-1:0] month;
    logic [DayW-1:0]   day;
  } req_t;

  typedef struct packed {
    logic              date_ok;
    logic [NumW-1:0]   day_number;
    logic [WdayW-1:0]  weekday;
    logic              leap_year;
    logic [MlenW-1:0]  month_length;
  } res_t;

  function automatic logic [MlenW-1:0] month_len(input logic [MonthW-1:0] m,
                                                 input logic leap);
    logic [MlenW-1:0] r;
    unique case (m)
      MonJan, MonMar, MonMay, MonJul, MonAug, MonOct, MonDec: r = MlenW'(31);
      MonApr, MonJun, MonSep, MonNov:                          r = MlenW'(30);
      MonFeb:  r = leap ? MlenW'(29) : MlenW'(28);
      default: r = '0;
    endcase
    return r;
  endfunction

  // (4*m + 23) / 10 for months after february, zero otherwise
  function automatic logic [2:0] month_corr(input logic [MonthW-1:0] m);
    logic [2:0] r;
    unique case (m)
      MonMar, MonApr:         r = 3'd3;
      MonMay, MonJun:         r = 3'd4;
      MonJul, MonAug, MonSep: r = 3'd5;
      MonOct, MonNov:         r = 3'd6;
      MonDec:                 r = 3'd7;
      default:                r = 3'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: hw/rtl/date_to_day_number_weekday.sv
// top level: gregorian date check, leap year, month length, day number and weekday
//
// One date is taken per cycle while req_stall is low. The four register
// stages are reciprocal division of the year by 100, the leap and range
// checks with the partial day sum, the final subtraction, and the mod 7
// fold of the day number. A stall on the result side holds each full stage
// with no bubble between it and the output, and backs up onto req_stall only when no bubble is left.
module date_to_day_number_weekday (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  dtdn_pkg::req_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output dtdn_pkg::res_t  res
);

  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;

  assign en4 = !v4 || !res_stall;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req_stall = !en1;
  assign res_valid = v4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= req_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  // stage 1: effective year and divisions by 100
  logic [dtdn_pkg::YearW-1:0]  ym_next;
  logic [dtdn_pkg::ProdW-1:0]  pq_year, pq_ym;
  logic [dtdn_pkg::YearW-1:0]  s1_year, s1_ym;
  logic [dtdn_pkg::MonthW-1:0] s1_month;
  logic [dtdn_pkg::DayW-1:0]   s1_day;
  logic [7:0]                  s1_qy, s1_qym;

  always_comb begin
    ym_next = (req.month <= dtdn_pkg::MonFeb) ? req.year - dtdn_pkg::YearW'(1) : req.year;
    pq_year = dtdn_pkg::ProdW'(req.year) * dtdn_pkg::ProdW'(dtdn_pkg::Recip100);
    pq_ym   = dtdn_pkg::ProdW'(ym_next) * dtdn_pkg::ProdW'(dtdn_pkg::Recip100);
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_year  <= req.year;
      s1_ym    <= ym_next;
      s1_month <= req.month;
      s1_day   <= req.day;
      s1_qy    <= pq_year[dtdn_pkg::Recip100Sh +: 8];
      s1_qym   <= pq_ym[dtdn_pkg::Recip100Sh +: 8];
    end
  end

  // stage 2: leap flag, month length, validity, partial sums
  logic                        leap_next, ok_next;
  logic [dtdn_pkg::MlenW-1:0]  mlen_next;
  logic [dtdn_pkg::NumW-1:0]   base_next;
  logic [10:0]                 sub_next;
  logic [9:0]                  cent3;
  logic                        s2_ok, s2_leap;
  logic [dtdn_pkg::MlenW-1:0]  s2_mlen;
  logic [dtdn_pkg::NumW-1:0]   s2_base;
  logic [10:0]                 s2_sub;

  always_comb begin
    leap_next = (s1_year[1:0] == 2'b00) &&
                ((s1_year != dtdn_pkg::YearW'(s1_qy) * dtdn_pkg::YearW'(100)) ||
                 (s1_qy[1:0] == 2'b00));
    mlen_next = dtdn_pkg::month_len(s1_month, leap_next);
    ok_next   = (mlen_next != '0) && (s1_day != '0) &&
                (dtdn_pkg::MlenW'(s1_day) <= mlen_next) && (s1_day[5] == 1'b0) &&
                (s1_year != '0) && (s1_year <= dtdn_pkg::YearMax);
    base_next = dtdn_pkg::NumW'(s1_year) * dtdn_pkg::NumW'(365)
              + dtdn_pkg::NumW'(s1_day)
              + dtdn_pkg::NumW'(s1_month - dtdn_pkg::MonthW'(1)) * dtdn_pkg::NumW'(31)
              + dtdn_pkg::NumW'(s1_ym[dtdn_pkg::YearW-1:2]);
    cent3     = (10'(s1_qym) + 10'd1) * 10'd3;
    sub_next  = 11'(cent3[9:2]) + 11'(dtdn_pkg::month_corr(s1_month));
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ok   <= ok_next;
      s2_leap <= leap_next;
      s2_mlen <= mlen_next;
      s2_base <= base_next;
      s2_sub  <= sub_next;
    end
  end

  // stage 3: final day number
  logic                       s3_ok, s3_leap;
  logic [dtdn_pkg::MlenW-1:0] s3_mlen;
  logic [dtdn_pkg::NumW-1:0]  s3_num;

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ok   <= s2_ok;
      s3_leap <= s2_leap;
      s3_mlen <= s2_mlen;
      s3_num  <= s2_ok ? s2_base - dtdn_pkg::NumW'(s2_sub) : '0;
    end
  end

  // stage 4: mod 7 by folding octal digits (8 is 1 mod 7)
  logic [23:0] num_pad;
  logic [5:0]  fold1;
  logic [3:0]  fold2;
  logic [2:0]  fold3;
  logic [2:0]  wday_next;

  always_comb begin
    num_pad = 24'(s3_num);
    fold1 = '0;
    for (int i = 0; i < 8; i++) begin
      fold1 = fold1 + 6'(num_pad[3*i +: 3]);
    end
    fold2 = 4'(fold1[5:3]) + 4'(fold1[2:0]);
    fold3 = 3'(fold2[3]) + fold2[2:0];
    wday_next = (fold3 == 3'd7) ? 3'd0 : fold3;
  end

  always_ff @(posedge clk) begin
    if (en4) begin
      res.date_ok      <= s3_ok;
      res.day_number   <= s3_num;
      res.weekday      <= wday_next;
      res.leap_year    <= s3_leap;
      res.month_length <= s3_mlen;
    end
  end

endmodule

FILE: tb/date_to_day_number_weekday_tb.sv
// testbench for the date to day number block: directed and random dates checked against a predictor
`timescale 1ns / 100ps

module date_to_day_number_weekday_tb;

  localparam int CycleLimit = 200000;
  localparam int HoldCycles = 150;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  dtdn_pkg::req_t req;
  logic res_valid;
  logic res_stall = 1'b0;
  dtdn_pkg::res_t res;

  logic hold_on = 1'b0;
  int idle_pct = 0;
  int stall_pct = 0;
  int cycle_cnt = 0;
  int mismatches = 0;
  int dates_sent = 0;
  int valid_sent = 0;
  int results_seen = 0;

  dtdn_pkg::res_t expected_days[$];
  dtdn_pkg::req_t pending_dates[$];

  date_to_day_number_weekday dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res(res)
  );

  always #2 clk = ~clk;

  function automatic dtdn_pkg::res_t date_outcome(dtdn_pkg::req_t d);
    dtdn_pkg::res_t e;
    int unsigned yr, mo, dy, yq, mlen, num;
    bit leap;
    bit ok;
    yr = 32'(d.year);
    mo = 32'(d.month);
    dy = 32'(d.day);
    leap = (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    case (d.month)
      dtdn_pkg::MonJan, dtdn_pkg::MonMar, dtdn_pkg::MonMay, dtdn_pkg::MonJul,
      dtdn_pkg::MonAug, dtdn_pkg::MonOct, dtdn_pkg::MonDec: mlen = 31;
      dtdn_pkg::MonApr, dtdn_pkg::MonJun, dtdn_pkg::MonSep, dtdn_pkg::MonNov: mlen = 30;
      dtdn_pkg::MonFeb: mlen = leap ? 29 : 28;
      default: mlen = 0;
    endcase
    ok = (mlen != 0) && (dy >= 1) && (dy <= mlen) && (yr >= 1) &&
         (yr <= dtdn_pkg::YearMax);
    num = 0;
    if (ok) begin
      yq = (d.month <= dtdn_pkg::MonFeb) ? yr - 1 : yr;
      num = 365 * yr + dy + 31 * (mo - 1) + yq / 4 - (3 * (yq / 100 + 1)) / 4;
      if (d.month > dtdn_pkg::MonFeb) num = num - (4 * mo + 23) / 10;
    end
    e.date_ok = ok;
    e.day_number = dtdn_pkg::NumW'(num);
    e.weekday = dtdn_pkg::WdayW'(num % 7);
    e.leap_year = leap;
    e.month_length = dtdn_pkg::MlenW'(mlen);
    return e;
  endfunction

  function automatic dtdn_pkg::req_t make_date(int unsigned y,
                                               logic [dtdn_pkg::MonthW-1:0] m,
                                               int unsigned dy);
    dtdn_pkg::req_t d;
    d.year = dtdn_pkg::YearW'(y);
    d.month = m;
    d.day = dtdn_pkg::DayW'(dy);
    return d;
  endfunction

  function automatic dtdn_pkg::req_t random_date();
    dtdn_pkg::req_t d;
    int unsigned pick;
    int unsigned lim;
    pick = $urandom_range(99);
    d.year = dtdn_pkg::YearW'($urandom_range(1, dtdn_pkg::YearMax));
    d.month = dtdn_pkg::MonthW'($urandom_range(dtdn_pkg::MonJan, dtdn_pkg::MonDec));
    d.day = dtdn_pkg::DayW'(1);
    if (pick < 75) begin
      case ($urandom_range(9))
        0: d.year = dtdn_pkg::YearW'(1);
        1: d.year = dtdn_pkg::YearMax;
        2: d.year = dtdn_pkg::YearW'(400 * $urandom_range(1, 24));
        3: d.year = dtdn_pkg::YearW'(100 * $urandom_range(1, 99));
        4: d.year = dtdn_pkg::YearW'(4 * $urandom_range(1, 2499));
        default: ;
      endcase
      lim = 32'(date_outcome(d).month_length);
      d.day = ($urandom_range(3) == 0) ? dtdn_pkg::DayW'(lim)
                                       : dtdn_pkg::DayW'($urandom_range(1, lim));
    end else if (pick < 88) begin
      d.day = dtdn_pkg::DayW'($urandom);
    end else begin
      d.year = dtdn_pkg::YearW'($urandom);
      d.month = dtdn_pkg::MonthW'($urandom);
      d.day = dtdn_pkg::DayW'($urandom);
    end
    return d;
  endfunction

  function automatic string field_msg(string field, dtdn_pkg::req_t d, int unsigned got,
                                      int unsigned want);
    return $sformatf("mismatch on %s for %0d/%0d/%0d: got %0d, expected %0d",
                     field, d.year, d.month, d.day, got, want);
  endfunction

  task automatic report_mismatch(string msg);
    $display("%s", msg);
    mismatches++;
  endtask

  task automatic send_date(dtdn_pkg::req_t d);
    while ($urandom_range(99) < idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= d;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_days.push_back(date_outcome(d));
    pending_dates.push_back(d);
    dates_sent++;
    if (date_outcome(d).date_ok) valid_sent++;
  endtask

  task automatic send_random_dates(int n, int sender_idle, int receiver_stall);
    idle_pct = sender_idle;
    stall_pct = receiver_stall;
    repeat (n) send_date(random_date());
  endtask

  task automatic test_directed_dates();
    idle_pct = 0;
    stall_pct = 0;
    send_date(make_date(1, dtdn_pkg::MonJan, 1));
    send_date(make_date(dtdn_pkg::YearMax, dtdn_pkg::MonDec, 31));
    send_date(make_date(2000, dtdn_pkg::MonFeb, 29));
    send_date(make_date(1900, dtdn_pkg::MonFeb, 29));
    send_date(make_date(1900, dtdn_pkg::MonFeb, 28));
    send_date(make_date(2024, dtdn_pkg::MonFeb, 29));
    send_date(make_date(2023, dtdn_pkg::MonFeb, 29));
    send_date(make_date(2023, dtdn_pkg::MonApr, 31));
    send_date(make_date(2023, dtdn_pkg::MonJun, 30));
    send_date(make_date(2023, dtdn_pkg::MonMar, 0));
    send_date(make_date(2023, dtdn_pkg::MonJan, 63));
    send_date(make_date(2023, dtdn_pkg::MonthW'(0), 10));
    send_date(make_date(2023, dtdn_pkg::MonthW'(13), 10));
    send_date(make_date(2023, dtdn_pkg::MonthW'(15), 63));
    send_date(make_date(0, dtdn_pkg::MonMar, 1));
    send_date(make_date(0, dtdn_pkg::MonFeb, 29));
    send_date(make_date(10000, dtdn_pkg::MonJan, 1));
    send_date(make_date(16383, dtdn_pkg::MonthW'(15), 63));
    send_date(make_date(0, dtdn_pkg::MonthW'(0), 0));
    send_date(make_date(2023, dtdn_pkg::MonMay, 31));
    send_date(make_date(2023, dtdn_pkg::MonJul, 4));
    send_date(make_date(2023, dtdn_pkg::MonAug, 31));
    send_date(make_date(2023, dtdn_pkg::MonSep, 15));
    send_date(make_date(2023, dtdn_pkg::MonOct, 31));
    send_date(make_date(2023, dtdn_pkg::MonNov, 30));
  endtask

  task automatic test_streaming();
    send_random_dates(130, 0, 0);
  endtask

  task automatic test_sender_gaps();
    send_random_dates(130, 60, 0);
  endtask

  task automatic test_receiver_stalls();
    send_random_dates(130, 0, 60);
  endtask

  task automatic test_both_idle();
    send_random_dates(130, 37, 37);
  endtask

  task automatic test_long_hold();
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_on <= 1'b1;
        for (int c = 0; c < HoldCycles; c++) @(posedge clk);
        hold_on <= 1'b0;
      end
      repeat (30) send_date(random_date());
    join
  endtask

  // receiver side stalls
  always @(posedge clk) begin
    if (rst) res_stall <= 1'b0;
    else res_stall <= hold_on || ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    dtdn_pkg::res_t want;
    dtdn_pkg::req_t d;
    if (!rst && res_valid && !res_stall) begin
      if (expected_days.size() == 0) begin
        report_mismatch($sformatf("result with no request pending, day_number %0d",
                                  res.day_number));
      end else begin
        want = expected_days.pop_front();
        d = pending_dates.pop_front();
        results_seen++;
        if (res.date_ok !== want.date_ok)
          report_mismatch(field_msg("date_ok", d, 32'(res.date_ok), 32'(want.date_ok)));
        if (res.day_number !== want.day_number)
          report_mismatch(field_msg("day_number", d, 32'(res.day_number),
                                    32'(want.day_number)));
        if (res.weekday !== want.weekday)
          report_mismatch(field_msg("weekday", d, 32'(res.weekday), 32'(want.weekday)));
        if (res.leap_year !== want.leap_year)
          report_mismatch(field_msg("leap_year", d, 32'(res.leap_year),
                                    32'(want.leap_year)));
        if (res.month_length !== want.month_length)
          report_mismatch(field_msg("month_length", d, 32'(res.month_length),
                                    32'(want.month_length)));
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_days.size());
      $display("date_to_day_number_weekday test failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed_dates();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_both_idle();
    test_long_hold();
    req_valid <= 1'b0;
    stall_pct = 0;
    while (expected_days.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("%0d dates sent (%0d valid), %0d results checked, %0d mismatches",
             dates_sent, valid_sent, results_seen, mismatches);
    $display("covered edge dates, streaming, sender gaps, output stalls and a long hold");
    if (mismatches == 0) $display("date_to_day_number_weekday test passed");
    else $display("date_to_day_number_weekday test failed");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/dtdn_pkg.sv
hw/rtl/date_to_day_number_weekday.sv
tb/date_to_day_number_weekday_tb.sv
